// ----- hw/rtl/ccm_pkg.sv -----
// Shared types and constants for the curved crossfade mixer.
// Holds the request payload structs, sequencer states and arithmetic unit commands.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package ccm_pkg;

    // Fraction bits of the internal unsigned fixed-point format (Q8.56).
    localparam int FRAC = 56;
    localparam logic [63:0] QONE   = 64'h0100_0000_0000_0000;
    localparam logic [63:0] TWO_Q  = 64'h0200_0000_0000_0000;
    localparam logic [63:0] FIVE_Q = 64'h0500_0000_0000_0000;

    localparam logic [22:0] FRAME_LIMIT = 23'd4194304;

    // Series lengths of the exponential and the logarithm.
    localparam logic [5:0] EXP_TERMS = 6'd60;
    localparam logic [5:0] LN_TERMS  = 6'd30;

    // Configuration register indexes.
    localparam logic [2:0] CFG_CURVE_MODE    = 3'd0;
    localparam logic [2:0] CFG_CHANNEL_COUNT = 3'd1;
    localparam logic [2:0] CFG_FRAME_COUNT   = 3'd2;
    localparam logic [2:0] CFG_FRAME_OFFSET  = 3'd3;
    localparam logic [2:0] CFG_SECOND_LENGTH = 3'd4;

    // Curve modes; the unused code behaves as exponential.
    localparam logic [1:0] CURVE_LOG = 2'd1;
    localparam logic [1:0] CURVE_SIG = 2'd2;

    // Phases of the logarithmic curve: ln 2, ln(i+1), ln(N+1).
    localparam logic [1:0] LN_PH_BASE = 2'd0;
    localparam logic [1:0] LN_PH_NUM  = 2'd1;
    localparam logic [1:0] LN_PH_DEN  = 2'd2;

    typedef struct packed {
        logic signed [15:0] sample_first;
        logic signed [15:0] sample_second;
    } t_in;

    typedef struct packed {
        logic signed [15:0] mixed_sample;
        logic               in_range;
        logic               last_sample;
    } t_out;

    typedef enum logic {
        OP_MUL,
        OP_DIV
    } t_arith_op;

    typedef struct packed {
        logic      start;
        t_arith_op op;
        logic      frac;
    } t_arith_req;

    typedef enum logic [4:0] {
        S_IDLE,
        S_IDX,
        S_T,
        S_SIG,
        S_EXP_INIT,
        S_EXP_MUL,
        S_EXP_DIV,
        S_EXP_END,
        S_SIG_DIV,
        S_LN_SET,
        S_LNU_U,
        S_LNU_SQ,
        S_LNU_MUL,
        S_LNU_DIV,
        S_LN_END,
        S_LN_DIV,
        S_RND,
        S_MIX1,
        S_MIX2,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ----- hw/rtl/ccm_arith.sv -----
// Shared multiply and divide unit of the crossfade mixer.
// Multiplies Q8.56 values over four 32x32 partial products, divides one bit a cycle.
// Depends on ccm_pkg.
`default_nettype none

module ccm_arith (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ccm_pkg::t_arith_req i_req,
    input  logic [63:0]         i_a,
    input  logic [63:0]         i_b,
    output logic                o_done,
    output logic [63:0]         o_result
);
    import ccm_pkg::*;

    localparam int DDW = 64 + FRAC;
    localparam logic [6:0] LAST_MUL  = 7'd3;
    localparam logic [6:0] LAST_INT  = 7'd63;
    localparam logic [6:0] LAST_FRAC = 7'(DDW - 1);

    logic             r_busy;
    logic             r_done;
    t_arith_op        r_op;
    logic [6:0]       r_cnt;
    logic [6:0]       r_last;
    logic [63:0]      r_a;
    logic [63:0]      r_b;
    logic [127:0]     r_acc;
    logic [63:0]      r_rem;
    logic [DDW-1:0]   r_dd;
    logic [63:0]      r_q;

    logic [31:0]      s_pa;
    logic [31:0]      s_pb;
    logic [63:0]      s_pp;
    logic [127:0]     s_pp_sh;
    logic [64:0]      s_rem2;
    logic             s_ge;

    always_comb begin
        s_pa = r_cnt[1] ? r_a[63:32] : r_a[31:0];
        s_pb = r_cnt[0] ? r_b[63:32] : r_b[31:0];
        s_pp = s_pa * s_pb;
        case (r_cnt[1:0])
            2'd0: begin
                s_pp_sh = {64'd0, s_pp};
            end
            2'd3: begin
                s_pp_sh = {s_pp, 64'd0};
            end
            default: begin
                s_pp_sh = {32'd0, s_pp, 32'd0};
            end
        endcase
        // Restoring division step: the remainder always stays below the divisor.
        s_rem2 = {r_rem, r_dd[DDW-1]};
        s_ge   = s_rem2 >= {1'b0, r_b};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == r_last)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op  <= i_req.op;
            r_a   <= i_a;
            r_b   <= i_b;
            r_cnt <= 7'd0;
            r_acc <= 128'd0;
            r_rem <= 64'd0;
            r_dd  <= {i_a, {FRAC{1'b0}}};
            if (i_req.op == OP_MUL) begin
                r_last <= LAST_MUL;
            end else if (i_req.frac) begin
                r_last <= LAST_FRAC;
            end else begin
                r_last <= LAST_INT;
            end
        end else if (r_busy) begin
            r_cnt <= r_cnt + 7'd1;
            if (r_op == OP_MUL) begin
                r_acc <= r_acc + s_pp_sh;
            end else begin
                r_rem <= s_ge ? 64'(s_rem2 - {1'b0, r_b}) : s_rem2[63:0];
                r_dd  <= r_dd << 1;
                r_q   <= {r_q[62:0], s_ge};
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = (r_op == OP_MUL) ? r_acc[FRAC+63:FRAC] : r_q;

endmodule

`default_nettype wire

// ----- hw/rtl/curved_crossfade_mixer.sv -----
// Curved crossfade mixer: one blended sample per request, one request at a time.
// The first channel of a frame computes the weight by series terms (exponential, sigmoid
// or logarithmic) run through the shared multiply/divide unit; later channels of the frame
// use the cached weight, and an out-of-range shifted index gives a zero sample unmixed.
// A new request is taken only after the last result has gone to the output register; a
// finished result waits in the output register. Reset (synchronous, active low) clears
// the counters, the weight cache and the output valid, and loads the configuration
// defaults; the datapath registers are not reset.
`default_nettype none

module curved_crossfade_mixer #(
    parameter int MAX_CHANNELS = 8,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ccm_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output ccm_pkg::t_out o_out,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_index,
    input  logic [25:0]   i_cfg_data
);
    import ccm_pkg::*;

    // Channel position width, channel count width, index and mix accumulator widths.
    localparam int CW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CNW = $clog2(MAX_CHANNELS + 1);
    localparam int IXW = 26 + CNW;
    localparam int AW  = WEIGHT_BITS + 19;
    localparam int RSH = FRAC - WEIGHT_BITS;
    localparam logic [63:0] ROUND_HALF = 64'd1 << (RSH - 1);
    localparam logic [WEIGHT_BITS:0] ONE_W = (WEIGHT_BITS + 1)'(1) << WEIGHT_BITS;

    // Configuration registers.
    logic [1:0]              r_mode, n_mode;
    logic [3:0]              r_cc, n_cc;
    logic [22:0]             r_fc, n_fc;
    logic signed [20:0]      r_off, n_off;
    logic [25:0]             r_slen, n_slen;

    // Position counters and the request being worked on.
    logic [21:0]             r_fpos, n_fpos;
    logic [CW-1:0]           r_cpos, n_cpos;
    logic [21:0]             r_i, n_i;
    logic [CW-1:0]           r_ch, n_ch;
    logic [CNW-1:0]          r_c, n_c;
    logic [22:0]             r_n, n_n;
    logic signed [15:0]      r_a, n_a;
    logic signed [15:0]      r_b, n_b;
    logic                    r_ok, n_ok;
    logic                    r_last, n_last;
    logic [15:0]             r_mix, n_mix;

    // Curve evaluation registers. In the logarithmic curve r_y holds ln(i+1) and
    // r_v holds ln(N+1) before the final quotient lands in r_v.
    logic [63:0]             r_t, n_t;
    logic [63:0]             r_y, n_y;
    logic [63:0]             r_term, n_term;
    logic [63:0]             r_sum, n_sum;
    logic [63:0]             r_v, n_v;
    logic [63:0]             r_u2, n_u2;
    logic [63:0]             r_ln2, n_ln2;
    logic [63:0]             r_z, n_z;
    logic [4:0]              r_lk, n_lk;
    logic [5:0]              r_k, n_k;
    logic [1:0]              r_lph, n_lph;
    logic                    r_pos, n_pos;

    // The weight depends only on the frame, so it is kept for the other channels.
    logic [WEIGHT_BITS:0]    r_w, n_w;
    logic                    r_wc_valid, n_wc_valid;
    logic [21:0]             r_wc_frame, n_wc_frame;
    logic signed [AW-1:0]    r_acc, n_acc;

    t_state                  r_state, n_state;
    logic                    r_wait, n_wait;
    logic                    r_out_valid, n_out_valid;
    t_out                    r_out, n_out;

    // Shared arithmetic unit.
    t_arith_req              s_req;
    logic [63:0]             s_op_a;
    logic [63:0]             s_op_b;
    logic                    s_ar_done;
    logic [63:0]             s_ar_res;

    // Helper terms.
    logic [CNW-1:0]          s_c_cl;
    logic [22:0]             s_n_cl;
    logic [21:0]             s_i_cur;
    logic [CW-1:0]           s_ch_cur;
    logic signed [23:0]      s_fo;
    logic signed [IXW-1:0]   s_idx;
    logic [63:0]             s_tt;
    logic [22:0]             s_m;
    logic [4:0]              s_msb;
    logic [63:0]             s_lnu;
    logic [63:0]             s_vr;
    logic [63:0]             s_wf;
    logic signed [16:0]      s_diff;
    logic signed [AW-1:0]    s_prod;
    logic signed [AW-1:0]    s_q;
    logic                    s_exec;

    ccm_arith u_arith (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (s_req),
        .i_a      (s_op_a),
        .i_b      (s_op_b),
        .o_done   (s_ar_done),
        .o_result (s_ar_res)
    );

    // Operand conditioning that does not depend on the state.
    always_comb begin
        if (r_cc == 4'd0) begin
            s_c_cl = CNW'(1);
        end else if ({28'd0, r_cc} > 32'(MAX_CHANNELS)) begin
            s_c_cl = CNW'(MAX_CHANNELS);
        end else begin
            s_c_cl = CNW'(r_cc);
        end
        if (r_fc == 23'd0) begin
            s_n_cl = 23'd1;
        end else if (r_fc > FRAME_LIMIT) begin
            s_n_cl = FRAME_LIMIT;
        end else begin
            s_n_cl = r_fc;
        end
        // Counters left beyond a shrunken count restart at zero.
        s_i_cur  = ({1'b0, r_fpos} >= s_n_cl) ? 22'd0 : r_fpos;
        s_ch_cur = (32'(r_cpos) >= 32'(s_c_cl)) ? CW'(0) : r_cpos;

        // Shifted second-stream index (i + offset) * C + ch.
        s_fo  = $signed({2'b00, r_i}) + 24'(r_off);
        s_idx = IXW'(s_fo) * $signed({1'b0, r_c}) + $signed({1'b0, r_ch});

        s_tt = (r_t << 3) + (r_t << 1);

        s_m = (r_lph == LN_PH_NUM) ? ({1'b0, r_i} + 23'd1) : (r_n + 23'd1);
        s_msb = 5'd0;
        for (int b = 0; b < 23; b++) begin
            if (s_m[b]) begin
                s_msb = 5'(b);
            end
        end
        s_lnu = r_sum << 1;

        s_vr = r_v + ROUND_HALF;
        s_wf = s_vr >> RSH;

        s_diff = $signed({r_b[15], r_b}) - $signed({r_a[15], r_a});
        s_prod = s_diff * $signed({1'b0, r_w});
        s_q    = r_acc >>> WEIGHT_BITS;
    end

    // Sequencer: next state, arithmetic commands and register updates.
    always_comb begin
        n_mode = r_mode;   n_cc = r_cc;       n_fc = r_fc;
        n_off = r_off;     n_slen = r_slen;
        n_fpos = r_fpos;   n_cpos = r_cpos;   n_i = r_i;       n_ch = r_ch;
        n_c = r_c;         n_n = r_n;         n_a = r_a;       n_b = r_b;
        n_ok = r_ok;       n_last = r_last;   n_mix = r_mix;
        n_t = r_t;         n_y = r_y;         n_term = r_term; n_sum = r_sum;
        n_v = r_v;         n_u2 = r_u2;       n_ln2 = r_ln2;   n_z = r_z;
        n_lk = r_lk;       n_k = r_k;         n_lph = r_lph;   n_pos = r_pos;
        n_w = r_w;         n_wc_valid = r_wc_valid;           n_wc_frame = r_wc_frame;
        n_acc = r_acc;     n_state = r_state; n_wait = r_wait;
        n_out_valid = r_out_valid;            n_out = r_out;

        s_req  = '{start: 1'b0, op: OP_MUL, frac: 1'b0};
        s_op_a = 64'd0;
        s_op_b = 64'd0;
        // An arithmetic state starts its operation once, then waits for the result.
        s_exec = r_wait && s_ar_done;

        if (o_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        // The user makes configuration writes only while idle (unenforced); any write drops the cached weight.
        if (i_cfg_we) begin
            n_wc_valid = 1'b0;
            case (i_cfg_index)
                CFG_CURVE_MODE: begin
                    n_mode = i_cfg_data[1:0];
                end
                CFG_CHANNEL_COUNT: begin
                    n_cc = i_cfg_data[3:0];
                end
                CFG_FRAME_COUNT: begin
                    n_fc = i_cfg_data[22:0];
                end
                CFG_FRAME_OFFSET: begin
                    n_off = $signed(i_cfg_data[20:0]);
                end
                CFG_SECOND_LENGTH: begin
                    n_slen = i_cfg_data;
                end
                default: begin
                end
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    // Take the request and advance the counters right away.
                    n_a    = i_in.sample_first;
                    n_b    = i_in.sample_second;
                    n_i    = s_i_cur;
                    n_ch   = s_ch_cur;
                    n_c    = s_c_cl;
                    n_n    = s_n_cl;
                    n_last = (32'(s_ch_cur) + 32'd1 == 32'(s_c_cl)) &&
                             ({1'b0, s_i_cur} + 23'd1 == s_n_cl);
                    if (32'(s_ch_cur) + 32'd1 >= 32'(s_c_cl)) begin
                        n_cpos = CW'(0);
                        n_fpos = ({1'b0, s_i_cur} + 23'd1 >= s_n_cl) ? 22'd0
                                                                       : s_i_cur + 22'd1;
                    end else begin
                        n_cpos = s_ch_cur + CW'(1);
                    end
                    n_state = S_IDX;
                end
            end
            S_IDX: begin
                n_ok  = !s_idx[IXW-1] && (s_idx < $signed({1'b0, r_slen}));
                n_mix = 16'd0;
                if (!n_ok) begin
                    n_state = S_DONE;
                end else if (r_wc_valid && (r_wc_frame == r_i)) begin
                    n_state = S_MIX1;
                end else begin
                    n_state = S_T;
                end
            end
            S_T: begin
                // t = i / N
                s_req  = '{start: !r_wait, op: OP_DIV, frac: 1'b1};
                s_op_a = {42'd0, r_i};
                s_op_b = {41'd0, r_n};
                n_wait = 1'b1;
                if (s_exec) begin
                    n_wait = 1'b0;
                    n_t    = s_ar_res;
                    n_y    = s_ar_res;
                    if (r_mode == CURVE_LOG) begin
                        n_lph   = LN_PH_BASE;
                        n_state = S_LN_SET;
                    end else if (r_mode == CURVE_SIG) begin
                        n_state = S_SIG;
                    end else begin
                        n_state = S_EXP_INIT;
                    end
                end
            end
            S_SIG: begin
                // The sigmoid is evaluated with a nonnegative exponent on either side of 0.5.
                if (s_tt >= FIVE_Q) begin
                    n_y   = s_tt - FIVE_Q;
                    n_pos = 1'b1;
                end else begin
                    n_y   = FIVE_Q - s_tt;
                    n_pos = 1'b0;
                end
                n_state = S_EXP_INIT;
            end
            S_EXP_INIT: begin
                n_term  = QONE;
                n_sum   = QONE;
                n_k     = 6'd1;
                n_state = S_EXP_MUL;
            end
            S_EXP_MUL: begin
                s_req  = '{start: !r_wait, op: OP_MUL, frac: 1'b0};
                s_op_a = r_term;
                s_op_b = r_y;
                n_wait = 1'b1;
                if (s_exec) begin
                    n_wait  = 1'b0;
                    n_term  = s_ar_res;
                    n_state = S_EXP_DIV;
                end
            end
            S_EXP_DIV: begin
                s_req  = '{start: !r_wait, op: OP_DIV, frac: 1'b0};
                s_op_a = r_term;
                s_op_b = {58'd0, r_k};
                n_wait = 1'b1;
                if (s_exec) begin
                    n_wait = 1'b0;
                    n_term = s_ar_res;
                    n_sum  = r_sum + s_ar_res;
                    if (r_k == EXP_TERMS) begin
                        n_state = S_EXP_END;
                    end else begin
                        n_k     = r_k + 6'd1;
                        n_state = S_EXP_MUL;
                    end
                end
            end
            S_EXP_END: begin
                if (r_mode == CURVE_SIG) begin
                    n_state = S_SIG_DIV;
                end else begin
                    n_v     = r_sum - QONE;
                    n_state = S_RND;
                end
            end
            S_SIG_DIV: begin
                s_req  = '{start: !r_wait, op: OP_DIV, frac: 1'b1};
                s_op_a = r_pos ? r_sum : QONE;
                s_op_b = r_sum + QONE;
                n_wait = 1'b1;
                if (s_exec) begin
                    n_wait  = 1'b0;
                    n_v     = s_ar_res;
                    n_state = S_RND;
                end
            end
            S_LN_SET: begin
                // Reduce the argument to [1, 2] by its leading bit position.
                if (r_lph == LN_PH_BASE) begin
                    n_z  = TWO_Q;
                    n_lk = 5'd0;
                end else begin
                    n_z  = {41'd0, s_m} << (6'(FRAC) - {1'b0, s_msb});
                    n_lk = s_msb;
                end
                n_state = S_LNU_U;
            end
            S_LNU_U: begin
                // u = (z - 1) / (z + 1), then ln z = 2 * atanh(u).
                s_req  = '{start: !r_wait, op: OP_DIV, frac: 1'b1};
                s_op_a = r_z - QONE;
                s_op_b = r_z + QONE;
                n_wait = 1'b1;
                if (s_exec) begin
                    n_wait  = 1'b0;
                    n_term  = s_ar_res;
                    n_sum   = s_ar_res;
                    n_state = S_LNU_SQ;
                end
            end
            S_LNU_SQ: begin
                s_req  = '{start: !r_wait, op: OP_MUL, frac: 1'b0};
                s_op_a = r_term;
                s_op_b = r_term;
                n_wait = 1'b1;
                if (s_exec) begin
                    n_wait  = 1'b0;
                    n_u2    = s_ar_res;
                    n_k     = 6'd1;
                    n_state = S_LNU_MUL;
                end
            end
            S_LNU_MUL: begin
                s_req  = '{start: !r_wait, op: OP_MUL, frac: 1'b0};
                s_op_a = r_term;
                s_op_b = r_u2;
                n_wait = 1'b1;
                if (s_exec) begin
                    n_wait  = 1'b0;
                    n_term  = s_ar_res;
                    n_state = S_LNU_DIV;
                end
            end
            S_LNU_DIV: begin
                s_req  = '{start: !r_wait, op: OP_DIV, frac: 1'b0};
                s_op_a = r_term;
                s_op_b = {57'd0, r_k, 1'b1};
                n_wait = 1'b1;
                if (s_exec) begin
                    n_wait = 1'b0;
                    n_sum  = r_sum + s_ar_res;
                    if (r_k == LN_TERMS) begin
                        n_state = S_LN_END;
                    end else begin
                        n_k     = r_k + 6'd1;
                        n_state = S_LNU_MUL;
                    end
                end
            end
            S_LN_END: begin
                case (r_lph)
                    LN_PH_BASE: begin
                        n_ln2   = s_lnu;
                        n_lph   = LN_PH_NUM;
                        n_state = S_LN_SET;
                    end
                    LN_PH_NUM: begin
                        n_y     = r_ln2 * r_lk + s_lnu;
                        n_lph   = LN_PH_DEN;
                        n_state = S_LN_SET;
                    end
                    default: begin
                        n_v     = r_ln2 * r_lk + s_lnu;
                        n_state = S_LN_DIV;
                    end
                endcase
            end
            S_LN_DIV: begin
                s_req  = '{start: !r_wait, op: OP_DIV, frac: 1'b1};
                s_op_a = r_y;
                s_op_b = r_v;
                n_wait = 1'b1;
                if (s_exec) begin
                    n_wait  = 1'b0;
                    n_v     = s_ar_res;
                    n_state = S_RND;
                end
            end
            S_RND: begin
                // Round half up to the weight precision and clamp to one.
                if (s_wf > 64'(ONE_W)) begin
                    n_w = ONE_W;
                end else begin
                    n_w = s_wf[WEIGHT_BITS:0];
                end
                n_wc_valid = 1'b1;
                n_wc_frame = r_i;
                n_state    = S_MIX1;
            end
            S_MIX1: begin
                // a * (1 - w) + b * w written as a * 1 + (b - a) * w.
                n_acc   = (AW'(r_a) <<< WEIGHT_BITS) + s_prod;
                n_state = S_MIX2;
            end
            S_MIX2: begin
                // Division by one truncates toward zero.
                if (r_acc[AW-1] && (r_acc[WEIGHT_BITS-1:0] != '0)) begin
                    n_mix = 16'(s_q + AW'(1));
                end else begin
                    n_mix = 16'(s_q);
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = '{mixed_sample: r_mix, in_range: r_ok,
                                    last_sample: r_last};
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wait      <= 1'b0;
            r_out_valid <= 1'b0;
            r_wc_valid  <= 1'b0;
            r_fpos      <= 22'd0;
            r_cpos      <= CW'(0);
            r_mode      <= 2'd0;
            r_cc        <= 4'd2;
            r_fc        <= 23'd1;
            r_off       <= 21'sd0;
            r_slen      <= 26'd0;
        end else begin
            r_state     <= n_state;
            r_wait      <= n_wait;
            r_out_valid <= n_out_valid;
            r_wc_valid  <= n_wc_valid;
            r_fpos      <= n_fpos;
            r_cpos      <= n_cpos;
            r_mode      <= n_mode;
            r_cc        <= n_cc;
            r_fc        <= n_fc;
            r_off       <= n_off;
            r_slen      <= n_slen;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i        <= n_i;
        r_ch       <= n_ch;
        r_c        <= n_c;
        r_n        <= n_n;
        r_a        <= n_a;
        r_b        <= n_b;
        r_ok       <= n_ok;
        r_last     <= n_last;
        r_mix      <= n_mix;
        r_t        <= n_t;
        r_y        <= n_y;
        r_term     <= n_term;
        r_sum      <= n_sum;
        r_v        <= n_v;
        r_u2       <= n_u2;
        r_ln2      <= n_ln2;
        r_z        <= n_z;
        r_lk       <= n_lk;
        r_k        <= n_k;
        r_lph      <= n_lph;
        r_pos      <= n_pos;
        r_w        <= n_w;
        r_wc_frame <= n_wc_frame;
        r_acc      <= n_acc;
        r_out      <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire
